FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_CLK(label, clk, prop)
`endif
`endif

FILE: rtl/core/uss_pkg.sv
// Types and constants of the update session sequencer.
package uss_pkg;
  localparam logic [7:0]  CodeAck = 8'h01;
  localparam logic [7:0]  CodeErr = 8'hFF;
  localparam logic [7:0]  CodeNone = 8'h00;
  localparam logic [7:0]  CheckSeed = 8'hAD;
  localparam logic [31:0] ErrCheck = 32'd20000;
  localparam logic [31:0] ErrSize = 32'd31000;
  localparam logic [31:0] ErrOpen = 32'd31001;
  localparam logic [31:0] ErrWrite = 32'd31002;
  localparam logic [31:0] ErrCommit = 32'd31003;
  localparam logic [31:0] ErrEnd = 32'd31004;
  localparam logic [31:0] StepCodeBase = 32'd30000;
  localparam logic [23:0] BlockLast = 24'hFFFFFF;
  localparam logic [7:0]  FileAll = 8'hFF;
  localparam logic [7:0]  FileLimit = 8'h80;
  localparam logic [1:0]  ActNone = 2'd0;
  localparam logic [1:0]  ActOpen = 2'd1;
  localparam logic [1:0]  ActAppend = 2'd2;
  localparam logic [1:0]  ActCommit = 2'd3;

  typedef enum logic [2:0] {
    KindSessStart, KindFileStart, KindData, KindFileEnd,
    KindSessEnd, KindCancel, KindNone, KindBadLen
  } kind_t;

  typedef struct packed {
    logic bad_check;
    kind_t kind;
    logic [31:0] block_word;
    logic [15:0] block_length;
    logic [31:0] first_count;
    logic [31:0] second_count;
    logic store_ok;
  } cmd_t;

  typedef struct packed {
    logic [7:0] reply_code;
    logic [31:0] reply_data;
    logic [7:0] reply_check;
    logic [1:0] store_action;
    logic reboot_request;
  } res_t;
endpackage

FILE: rtl/core/uss_in_if.sv
// Input channel interface of the update session sequencer.
interface uss_in_if;
  logic valid;
  logic ready;
  logic header_match;
  logic length_ok;
  logic [7:0] calc_xor;
  logic [7:0] check_byte;
  logic [31:0] block_word;
  logic [15:0] block_length;
  logic [31:0] first_count;
  logic [31:0] second_count;
  logic store_ok;
  modport source(output valid, header_match, length_ok, calc_xor, check_byte, block_word,
    block_length, first_count, second_count, store_ok, input ready);
  modport sink(input valid, header_match, length_ok, calc_xor, check_byte, block_word,
    block_length, first_count, second_count, store_ok, output ready);
endinterface

FILE: rtl/core/uss_out_if.sv
// Output channel interface of the update session sequencer.
interface uss_out_if;
  logic valid;
  logic ready;
  logic [7:0] reply_code;
  logic [31:0] reply_data;
  logic [7:0] reply_check;
  logic [1:0] store_action;
  logic reboot_request;
  modport source(output valid, reply_code, reply_data, reply_check, store_action,
    reboot_request, input ready);
  modport sink(input valid, reply_code, reply_data, reply_check, store_action,
    reboot_request, output ready);
endinterface

FILE: rtl/core/uss_front.sv
// Front end: filters headers and classifies each packet into a command.
module uss_front
  import uss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  uss_in_if.sink in,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_ready
);
  logic [23:0] blk;
  logic [7:0] fno;
  logic zlen;
  kind_t kind;

  assign in.ready = !cmd_valid || cmd_ready;
  assign blk = in.block_word[23:0];
  assign fno = in.block_word[31:24];
  assign zlen = (in.block_length == 16'd0);

  always_comb begin
    if (!in.length_ok) kind = KindBadLen;
    else if (blk == 24'd0 && fno == 8'd0) kind = KindSessStart;
    else if (blk == 24'd0 && fno < FileLimit) kind = KindFileStart;
    else if (blk != 24'd0 && fno != 8'd0 && !zlen) kind = KindData;
    else if (blk == BlockLast && fno != FileAll && fno != 8'd0 && zlen) kind = KindFileEnd;
    else if (blk == BlockLast && fno == FileAll && zlen) kind = KindSessEnd;
    else if (blk == 24'd0 && fno == FileAll && zlen) kind = KindCancel;
    else kind = KindNone;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in.ready) begin
      cmd_valid <= in.valid && in.header_match;
    end
    if (in.ready && in.valid) begin
      cmd.bad_check <= in.calc_xor != in.check_byte;
      cmd.kind <= kind;
      cmd.block_word <= in.block_word;
      cmd.block_length <= in.block_length;
      cmd.first_count <= in.first_count;
      cmd.second_count <= in.second_count;
      cmd.store_ok <= in.store_ok;
    end
  end
endmodule

FILE: rtl/core/uss_back.sv
// Back end: session state, checks and reply formation.
module uss_back
  import uss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_ready,
  uss_out_if.source out
);
`include "assert_macros.svh"
  typedef enum logic [2:0] {
    StIdle, StSession, StFileStart, StReceive, StFileEnd
  } state_t;

  state_t state, state_next;
  logic [31:0] total_files, total_bytes, expected_blocks, received_blocks;
  logic [31:0] expected_bytes, received_bytes, files_done, session_bytes;
  logic [7:0] file_index;
  logic [23:0] last_block;
  logic [31:0] total_files_next, total_bytes_next, expected_blocks_next;
  logic [31:0] received_blocks_next, expected_bytes_next, received_bytes_next;
  logic [31:0] files_done_next, session_bytes_next;
  logic [7:0] file_index_next;
  logic [23:0] last_block_next;
  logic [7:0] code;
  logic [31:0] data;
  logic [1:0] act;
  logic reboot;
  logic [23:0] blk, want;
  logic [7:0] fno;
  logic take;

  assign cmd_ready = !out.valid || out.ready;
  assign take = cmd_valid && cmd_ready;
  assign blk = cmd.block_word[23:0];
  assign fno = cmd.block_word[31:24];
  assign want = (state == StFileStart) ? 24'd1 : last_block + 24'd1;

  always_comb begin
    state_next = state;
    total_files_next = total_files;
    total_bytes_next = total_bytes;
    expected_blocks_next = expected_blocks;
    received_blocks_next = received_blocks;
    expected_bytes_next = expected_bytes;
    received_bytes_next = received_bytes;
    files_done_next = files_done;
    session_bytes_next = session_bytes;
    file_index_next = file_index;
    last_block_next = last_block;
    code = CodeAck;
    data = cmd.block_word;
    act = ActNone;
    reboot = 1'b0;
    if (cmd.kind == KindBadLen) begin
      code = CodeErr; data = ErrSize;
    end else if (cmd.bad_check) begin
      code = CodeErr; data = ErrCheck;
    end else begin
      unique case (cmd.kind)
        KindSessStart: begin
          if (state == StIdle) begin
            total_files_next = cmd.first_count;
            total_bytes_next = cmd.second_count;
            state_next = StSession;
          end
        end
        KindFileStart: begin
          if (state == StSession && fno != 8'd1) begin
            code = CodeErr; data = StepCodeBase + 32'd1;
          end else if (state == StFileEnd && fno != file_index + 8'd1) begin
            code = CodeErr; data = {file_index, 24'd0};
          end else if (state == StSession || state == StFileEnd) begin
            file_index_next = fno;
            expected_bytes_next = cmd.first_count;
            expected_blocks_next = cmd.second_count;
            act = ActOpen;
            if (cmd.store_ok) state_next = StFileStart;
            else begin
              code = CodeErr; data = ErrOpen;
            end
          end
        end
        KindData: begin
          if (state == StFileStart || state == StReceive) begin
            if (fno == file_index && blk == want) begin
              act = ActAppend;
              if (cmd.store_ok) begin
                received_bytes_next = received_bytes + {16'd0, cmd.block_length};
                received_blocks_next = received_blocks + 32'd1;
                last_block_next = blk;
                state_next = StReceive;
              end else begin
                code = CodeErr; data = ErrWrite;
              end
            end else begin
              code = CodeErr;
              data = {file_index, (state == StReceive) ? last_block : 24'd0};
            end
          end
        end
        KindFileEnd: begin
          if (state == StReceive) begin
            if (fno == file_index && received_blocks == expected_blocks &&
                received_bytes == expected_bytes) begin
              act = ActCommit;
              if (cmd.store_ok) begin
                files_done_next = files_done + 32'd1;
                session_bytes_next = session_bytes + received_bytes;
                received_bytes_next = 32'd0;
                received_blocks_next = 32'd0;
                state_next = StFileEnd;
              end else begin
                code = CodeErr; data = ErrCommit;
              end
            end else begin
              code = CodeErr; data = {file_index, last_block};
            end
          end
        end
        KindSessEnd: begin
          if (state == StFileEnd) begin
            if (files_done == total_files && session_bytes == total_bytes) reboot = 1'b1;
            else begin
              code = CodeErr; data = ErrEnd;
            end
          end
        end
        KindCancel: reboot = 1'b1;
        KindNone: begin
          code = CodeNone; data = 32'd0;
        end
        default: begin
          code = CodeErr; data = ErrSize;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      total_files <= 32'd0;
      total_bytes <= 32'd0;
      expected_blocks <= 32'd0;
      received_blocks <= 32'd0;
      expected_bytes <= 32'd0;
      received_bytes <= 32'd0;
      files_done <= 32'd0;
      session_bytes <= 32'd0;
      file_index <= 8'd1;
      last_block <= 24'd1;
      out.valid <= 1'b0;
    end else begin
      if (cmd_ready) out.valid <= cmd_valid;
      if (take) begin
        state <= state_next;
        total_files <= total_files_next;
        total_bytes <= total_bytes_next;
        expected_blocks <= expected_blocks_next;
        received_blocks <= received_blocks_next;
        expected_bytes <= expected_bytes_next;
        received_bytes <= received_bytes_next;
        files_done <= files_done_next;
        session_bytes <= session_bytes_next;
        file_index <= file_index_next;
        last_block <= last_block_next;
      end
    end
    if (take) begin
      out.reply_code <= code;
      out.reply_data <= data;
      out.reply_check <= CheckSeed ^ code ^ data[7:0] ^ data[15:8] ^ data[23:16] ^ data[31:24];
      out.store_action <= act;
      out.reboot_request <= reboot;
    end
  end

  `ASSERT_IMPL(a_hold, clk, rst, out.valid && !out.ready |=> out.valid && $stable(out.reply_data))
  `ASSERT_IMPL(a_reboot_ack, clk, rst, out.valid && out.reboot_request |-> out.reply_code == CodeAck)
  `ASSERT_IMPL(a_recv_file, clk, rst, state == StReceive |-> file_index != 8'd0)
endmodule

FILE: rtl/core/update_session_sequencer.sv
// Top level of the update session sequencer.
// Takes one digested update packet header per beat and returns at most one
// reply beat. It sustains one beat per cycle while the reply side is ready,
// because every session check and counter update is a combinational compare
// or add. An input beat is held first in the front register and then in the
// reply register; stalls on the reply side hold it longer. Packets with a
// mismatched header give no reply. The front stage classifies packets, and
// its register is the one-entry queue to the back stage.
module update_session_sequencer
  import uss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  uss_in_if.sink in,
  uss_out_if.source out
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  uss_front u_front (.clk, .rst, .in, .cmd_valid, .cmd, .cmd_ready);
  uss_back u_back (.clk, .rst, .cmd_valid, .cmd, .cmd_ready, .out);
endmodule
